// File: rtl/core/spli_pkg.sv
package spli_pkg;

    // Field widths of the pulse and time values.
    localparam int PULSE_BITS = 12;
    localparam int TIME_BITS  = 16;

    // Working width of the shared adder: holds 2*|diff|*elapsed + duration.
    localparam int RAMP_W = PULSE_BITS + TIME_BITS + 2;

    // Step counter width, enough for the longer of the two loops.
    localparam int CNT_W = $clog2((TIME_BITS > PULSE_BITS) ? TIME_BITS : PULSE_BITS);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_MIN = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_MAX = 1'd1;

    // Configuration reset values.
    localparam logic [PULSE_BITS-1:0] PULSE_MIN_RESET = PULSE_BITS'(500);
    localparam logic [PULSE_BITS-1:0] PULSE_MAX_RESET = PULSE_BITS'(2500);

    // Command function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Command item.
    typedef struct packed {
        logic                  func;
        logic [PULSE_BITS-1:0] init_width;
        logic [PULSE_BITS-1:0] goal_width;
        logic [TIME_BITS-1:0]  ramp_ms;
    } spli_in_t;

    // Result item.
    typedef struct packed {
        logic [PULSE_BITS-1:0] pulse_out;
        logic                  moving;
    } spli_out_t;

    // Request to the ramp engine.
    typedef struct packed {
        logic                  go;
        logic                  diff_neg;
        logic [PULSE_BITS-1:0] diff_mag;
        logic [TIME_BITS-1:0]  elapsed;
        logic [TIME_BITS-1:0]  length;
    } ramp_req_t;

    // Answer from the ramp engine: signed quotient as sign and magnitude.
    typedef struct packed {
        logic                  done;
        logic                  q_neg;
        logic [PULSE_BITS-1:0] q;
    } ramp_rsp_t;

endpackage

// File: rtl/core/servo_pulse_linear_interpolator_core.sv
// Servo pulse ramp generator. A start command loads a move and presents the
// clamped start pulse (or the target when nothing moves) by way of the pending
// register and then the result register. A tick command advances the elapsed
// count by one millisecond; ticks that land while idle or at the end of the
// move also answer through those same two registers. A tick inside a move runs
// the ramp engine: 16 multiply steps, one or two steps to form the rounding
// numerator (two when a falling ramp needs the extra numerator step) and 12
// divide steps, all on one shared adder; the final offset and clamp are then
// registered into the pending register before the result is handed over. A
// stalled result holds the next one in the pending register. One command is
// worked on at a time; the next may be transferred while the previous result
// waits.
module servo_pulse_linear_interpolator_core
    import spli_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  spli_in_t                cmd,
    output logic                    res_valid,
    input  logic                    res_stall,
    output spli_out_t               res,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PULSE_BITS-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_OUT  = 3'b100
    } st_t;

    st_t                   state_reg, state_next;
    logic [PULSE_BITS-1:0] pmin_reg, pmax_reg;
    logic [PULSE_BITS-1:0] start_reg, start_next;
    logic [PULSE_BITS-1:0] end_reg, end_next;
    logic [TIME_BITS-1:0]  len_reg, len_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic                  active_reg, active_next;
    spli_out_t             pend_reg, pend_next;
    spli_out_t             res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  accept;
    logic                  slot_free;
    logic [TIME_BITS-1:0]  elapsed_inc;
    logic [PULSE_BITS-1:0] target_clamped;
    logic                  new_active;
    logic signed [PULSE_BITS+1:0] offset_s, ramp_sum;
    ramp_req_t             ramp_req;
    ramp_rsp_t             ramp_rsp;

    // Clamp tests the lower bound first, then the upper one.
    function automatic logic [PULSE_BITS-1:0] clamp_width(
        input logic signed [PULSE_BITS+1:0] v,
        input logic [PULSE_BITS-1:0]        lo,
        input logic [PULSE_BITS-1:0]        hi
    );
        logic signed [PULSE_BITS+1:0] lo_s;
        logic signed [PULSE_BITS+1:0] hi_s;
        begin
            lo_s = signed'({2'b00, lo});
            hi_s = signed'({2'b00, hi});
            if (v < lo_s)
                clamp_width = lo;
            else if (v > hi_s)
                clamp_width = hi;
            else
                clamp_width = v[PULSE_BITS-1:0];
        end
    endfunction

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign slot_free = !res_valid_reg || !res_stall;

    assign elapsed_inc    = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign target_clamped = clamp_width(signed'({2'b00, cmd.goal_width}), pmin_reg, pmax_reg);
    assign new_active     = (cmd.init_width != target_clamped) && (cmd.ramp_ms != '0);

    // Ramp request for a tick that falls inside an active move.
    assign ramp_req.go       = accept && (cmd.func == FUNC_TICK) && active_reg
                               && (elapsed_inc < len_reg);
    assign ramp_req.diff_neg = end_reg < start_reg;
    assign ramp_req.diff_mag = (end_reg < start_reg) ? (start_reg - end_reg)
                                                     : (end_reg - start_reg);
    assign ramp_req.elapsed  = elapsed_inc;
    assign ramp_req.length   = len_reg;

    spli_ramp u_ramp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ramp_req),
        .rsp   (ramp_rsp)
    );

    // Apply the signed offset to the start pulse.
    assign offset_s = ramp_rsp.q_neg ? -signed'({2'b00, ramp_rsp.q})
                                     : signed'({2'b00, ramp_rsp.q});
    assign ramp_sum = signed'({2'b00, start_reg}) + offset_s;

    // Command handling and result hand-off.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        len_next       = len_reg;
        elapsed_next   = elapsed_reg;
        active_next    = active_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == FUNC_START)
                    begin
                        start_next          = cmd.init_width;
                        end_next            = target_clamped;
                        len_next            = cmd.ramp_ms;
                        elapsed_next        = '0;
                        active_next         = new_active;
                        pend_next.moving    = new_active;
                        pend_next.pulse_out = new_active
                            ? clamp_width(signed'({2'b00, cmd.init_width}), pmin_reg, pmax_reg)
                            : target_clamped;
                        state_next          = ST_OUT;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                        if (ramp_req.go)
                        begin
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            active_next         = 1'b0;
                            pend_next.moving    = 1'b0;
                            pend_next.pulse_out = end_reg;
                            state_next          = ST_OUT;
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (ramp_rsp.done)
                begin
                    pend_next.moving    = 1'b1;
                    pend_next.pulse_out = clamp_width(ramp_sum, pmin_reg, pmax_reg);
                    state_next          = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and move state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= '0;
            end_reg       <= '0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            len_reg       <= len_next;
            elapsed_reg   <= elapsed_next;
            active_reg    <= active_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Clamp bound registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg <= PULSE_MIN_RESET;
            pmax_reg <= PULSE_MAX_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PULSE_MIN)
                pmin_reg <= cfg_data;
            else if (cfg_index == CFG_PULSE_MAX)
                pmax_reg <= cfg_data;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/core/spli_alu.sv
module spli_alu
    import spli_pkg::*;
(
    input  logic [RAMP_W-1:0] a,
    input  logic [RAMP_W-1:0] b,
    input  logic              sub,
    output logic [RAMP_W-1:0] result,
    output logic              borrow
);

    logic [RAMP_W:0] full_sum;

    // One adder serves both add and subtract; subtract is a plus inverted b plus one.
    assign full_sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{RAMP_W{1'b0}}, sub};
    assign result   = full_sum[RAMP_W-1:0];
    assign borrow   = sub & ~full_sum[RAMP_W];

endmodule

// File: rtl/core/spli_ramp.sv
module spli_ramp
    import spli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ramp_req_t req,
    output ramp_rsp_t rsp
);

    typedef enum logic [4:0] {
        R_IDLE = 5'b00001,
        R_MUL  = 5'b00010,
        R_FORM = 5'b00100,
        R_FIX  = 5'b01000,
        R_DIV  = 5'b10000
    } r_state_t;

    r_state_t                state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;

    logic [RAMP_W-1:0]       acc_reg, acc_next;
    logic [RAMP_W-1:0]       mcand_reg, mcand_next;
    logic [TIME_BITS-1:0]    mplier_reg, mplier_next;
    logic [RAMP_W-1:0]       dsh_reg, dsh_next;
    logic [TIME_BITS-1:0]    len_reg, len_next;
    logic                    dneg_reg, dneg_next;
    logic                    qneg_reg, qneg_next;
    logic [PULSE_BITS-1:0]   q_reg, q_next;

    logic [RAMP_W-1:0]       alu_a, alu_b, alu_res;
    logic                    alu_sub, alu_borrow;
    logic [RAMP_W-1:0]       acc_x2, len_ext;

    assign acc_x2  = {acc_reg[RAMP_W-2:0], 1'b0};
    assign len_ext = RAMP_W'(len_reg);

    spli_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    // Operand selection for the shared adder in each phase.
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;
        case (state_reg)
            R_MUL:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
            R_FORM:
            begin
                alu_a   = acc_x2;
                alu_b   = len_ext;
                alu_sub = dneg_reg;
            end
            R_FIX:
            begin
                alu_a   = len_ext;
                alu_b   = acc_x2;
                alu_sub = 1'b1;
            end
            R_DIV:
            begin
                alu_a   = acc_reg;
                alu_b   = dsh_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer: shift-add multiply, numerator forming, restoring divide.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dsh_next    = dsh_reg;
        len_next    = len_reg;
        dneg_next   = dneg_reg;
        qneg_next   = qneg_reg;
        q_next      = q_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (req.go)
                begin
                    acc_next    = '0;
                    mcand_next  = RAMP_W'(req.diff_mag);
                    mplier_next = req.elapsed;
                    len_next    = req.length;
                    dneg_next   = req.diff_neg;
                    cnt_next    = '0;
                    state_next  = R_MUL;
                end
            end
            R_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_res;
                end
                mcand_next  = {mcand_reg[RAMP_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TIME_BITS - 1))
                begin
                    state_next = R_FORM;
                end
            end
            R_FORM:
            begin
                // Numerator is 2*diff*elapsed + duration; keep its magnitude and sign.
                dsh_next = len_ext << PULSE_BITS;
                cnt_next = '0;
                q_next   = '0;
                if (!dneg_reg)
                begin
                    acc_next   = alu_res;
                    qneg_next  = 1'b0;
                    state_next = R_DIV;
                end
                else if (!alu_borrow)
                begin
                    acc_next   = alu_res;
                    qneg_next  = 1'b1;
                    state_next = R_DIV;
                end
                else
                begin
                    state_next = R_FIX;
                end
            end
            R_FIX:
            begin
                // Negative offset smaller than half a step: numerator stays positive.
                dsh_next   = len_ext << PULSE_BITS;
                cnt_next   = '0;
                q_next     = '0;
                acc_next   = alu_res;
                qneg_next  = 1'b0;
                state_next = R_DIV;
            end
            R_DIV:
            begin
                if (!alu_borrow)
                begin
                    acc_next = alu_res;
                end
                q_next   = {q_reg[PULSE_BITS-2:0], ~alu_borrow};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PULSE_BITS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dsh_reg    <= dsh_next;
        len_reg    <= len_next;
        dneg_reg   <= dneg_next;
        qneg_reg   <= qneg_next;
        q_reg      <= q_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.q_neg = qneg_reg;
    assign rsp.q     = q_reg;

endmodule

// File: rtl/core/spli_checker.sv
module spli_checker
    import spli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  logic      res_valid,
    input  logic      res_stall,
    input  spli_out_t res
);

    // A held result keeps its value until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("result changed while stalled");

    // Every accepted command makes the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command accepted without going busy");

    // A fresh result only appears from a command in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result appeared without a command");

    // Leaving busy always coincides with a result being presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_stall) |-> res_valid)
        else $error("command finished without a result");

endmodule

bind servo_pulse_linear_interpolator_core spli_checker u_spli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
